FILE: design/usbep0_pkg.sv
// ----------------------------------------------------------------------------
// usbep0_pkg
// Shared types and codes for the endpoint zero standard request handler.
// ----------------------------------------------------------------------------
package usbep0_pkg;

    // result action codes
    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_STALL   = 3'd1,
        ACT_DATA    = 3'd2,
        ACT_STATUS  = 3'd3,
        ACT_FORWARD = 3'd4
    } action_t;

    // device state
    typedef enum logic [1:0] {
        ST_DEFAULT    = 2'd0,
        ST_ADDRESSED  = 2'd1,
        ST_CONFIGURED = 2'd2
    } usb_state_t;

    // class handler event codes
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_INIT   = 2'd1,
        EV_DEINIT = 2'd2
    } class_event_t;

    // what the back end has to do with an item
    typedef enum logic [2:0] {
        CLS_IN_DONE = 3'd0,
        CLS_FIXED   = 3'd1,
        CLS_SET_ADR = 3'd2,
        CLS_SET_CFG = 3'd3,
        CLS_GET_CFG = 3'd4,
        CLS_IFACE   = 3'd5
    } req_class_t;

    // item operation codes
    localparam logic OP_SETUP   = 1'b0;
    localparam logic OP_IN_DONE = 1'b1;

    // standard request codes
    localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIG     = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIG     = 8'd9;

    // request type and recipient codes
    localparam logic [1:0] TYPE_STANDARD  = 2'd0;
    localparam logic [1:0] TYPE_RESERVED  = 2'd3;
    localparam logic [4:0] RCP_DEVICE     = 5'd0;
    localparam logic [4:0] RCP_INTERFACE  = 5'd1;

    // descriptor types
    localparam logic [7:0] DT_DEVICE    = 8'd1;
    localparam logic [7:0] DT_CONFIG    = 8'd2;
    localparam logic [7:0] DT_STRING    = 8'd3;
    localparam logic [7:0] DT_QUALIFIER = 8'd6;

    // string indexes
    localparam logic [7:0] STR_LANGID  = 8'd0;
    localparam logic [7:0] STR_MAKER   = 8'd1;
    localparam logic [7:0] STR_PRODUCT = 8'd2;
    localparam logic [7:0] STR_SERIAL  = 8'd3;
    localparam logic [7:0] STR_CFGNAME = 8'd4;
    localparam logic [7:0] STR_IFNAME  = 8'd5;

    // descriptor selector codes on the result
    localparam logic [3:0] KIND_DEVICE    = 4'd0;
    localparam logic [3:0] KIND_CONFIG    = 4'd1;
    localparam logic [3:0] KIND_QUALIFIER = 4'd2;
    localparam logic [3:0] KIND_STR_BASE  = 4'd3;
    localparam logic [3:0] KIND_CFG_BYTE  = 4'd9;

    // configuration register indexes
    localparam logic [2:0] REG_DEVICE_LEN  = 3'd0;
    localparam logic [2:0] REG_CONFIG_LEN  = 3'd1;
    localparam logic [2:0] REG_QUAL_LEN    = 3'd2;
    localparam logic [2:0] REG_LANGID_LEN  = 3'd3;
    localparam logic [2:0] REG_MAKER_LEN   = 3'd4;
    localparam logic [2:0] REG_PRODUCT_LEN = 3'd5;
    localparam logic [2:0] REG_SERIAL_LEN  = 3'd6;
    localparam logic [2:0] REG_CFGNAME_LEN = 3'd7;

    // configuration register reset values
    localparam logic [7:0]  RST_DEVICE_LEN = 8'd18;
    localparam logic [15:0] RST_CONFIG_LEN = 16'd67;
    localparam logic [7:0]  RST_QUAL_LEN   = 8'd10;
    localparam logic [7:0]  RST_LANGID_LEN = 8'd4;

    // classified request, passed from front end to back end
    typedef struct packed {
        req_class_t  cls;
        action_t     action;
        logic [3:0]  kind;
        logic [15:0] length;
        logic        ok;
        logic [6:0]  addr;
        logic        idx_zero;
        logic        idx_one;
    } ep0_item_t;

endpackage

FILE: design/usbep0_front.sv
// ----------------------------------------------------------------------------
// usbep0_front
// Holds the descriptor length registers and classifies each incoming item.
// ----------------------------------------------------------------------------
module usbep0_front #(
    parameter int MAX_CONFIGS       = 1,
    parameter int MAX_INTERFACES    = 2,
    parameter int IFNAME_STR_LENGTH = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [15:0]            cfg_data,
    input  logic                   op,
    input  logic [7:0]             req_type,
    input  logic [7:0]             req_code,
    input  logic [15:0]            req_value,
    input  logic [15:0]            req_index,
    input  logic [15:0]            req_length,
    output usbep0_pkg::ep0_item_t  item
);

    localparam logic [7:0] MAX_CFG_B = 8'(MAX_CONFIGS);
    localparam logic [7:0] MAX_IF_B  = 8'(MAX_INTERFACES);
    localparam logic [7:0] IFNAME_B  = 8'(IFNAME_STR_LENGTH);

    logic [7:0]  device_len_reg;
    logic [15:0] config_len_reg;
    logic [7:0]  qual_len_reg;
    logic [7:0]  langid_len_reg;
    logic [7:0]  maker_len_reg;
    logic [7:0]  product_len_reg;
    logic [7:0]  serial_len_reg;
    logic [7:0]  cfgname_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_len_reg  <= usbep0_pkg::RST_DEVICE_LEN;
            config_len_reg  <= usbep0_pkg::RST_CONFIG_LEN;
            qual_len_reg    <= usbep0_pkg::RST_QUAL_LEN;
            langid_len_reg  <= usbep0_pkg::RST_LANGID_LEN;
            maker_len_reg   <= '0;
            product_len_reg <= '0;
            serial_len_reg  <= '0;
            cfgname_len_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                usbep0_pkg::REG_DEVICE_LEN:  device_len_reg  <= cfg_data[7:0];
                usbep0_pkg::REG_CONFIG_LEN:  config_len_reg  <= cfg_data;
                usbep0_pkg::REG_QUAL_LEN:    qual_len_reg    <= cfg_data[7:0];
                usbep0_pkg::REG_LANGID_LEN:  langid_len_reg  <= cfg_data[7:0];
                usbep0_pkg::REG_MAKER_LEN:   maker_len_reg   <= cfg_data[7:0];
                usbep0_pkg::REG_PRODUCT_LEN: product_len_reg <= cfg_data[7:0];
                usbep0_pkg::REG_SERIAL_LEN:  serial_len_reg  <= cfg_data[7:0];
                usbep0_pkg::REG_CFGNAME_LEN: cfgname_len_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic [1:0]  type_kind;
    logic [4:0]  recip;
    logic [7:0]  dtype;
    logic [7:0]  sidx;
    logic        desc_valid;
    logic [3:0]  desc_kind;
    logic [15:0] desc_len;

    assign type_kind = req_type[6:5];
    assign recip     = req_type[4:0];
    assign dtype     = req_value[15:8];
    assign sidx      = req_value[7:0];

    // descriptor lookup
    always_comb
    begin
        desc_valid = 1'b1;
        desc_kind  = usbep0_pkg::KIND_DEVICE;
        desc_len   = '0;
        unique case (dtype)
            usbep0_pkg::DT_DEVICE:
            begin
                desc_kind = usbep0_pkg::KIND_DEVICE;
                desc_len  = {8'd0, device_len_reg};
            end
            usbep0_pkg::DT_CONFIG:
            begin
                desc_kind = usbep0_pkg::KIND_CONFIG;
                desc_len  = config_len_reg;
            end
            usbep0_pkg::DT_QUALIFIER:
            begin
                desc_kind = usbep0_pkg::KIND_QUALIFIER;
                desc_len  = {8'd0, qual_len_reg};
            end
            usbep0_pkg::DT_STRING:
            begin
                desc_kind = usbep0_pkg::KIND_STR_BASE + sidx[3:0];
                unique case (sidx)
                    usbep0_pkg::STR_LANGID:  desc_len = {8'd0, langid_len_reg};
                    usbep0_pkg::STR_MAKER:   desc_len = {8'd0, maker_len_reg};
                    usbep0_pkg::STR_PRODUCT: desc_len = {8'd0, product_len_reg};
                    usbep0_pkg::STR_SERIAL:  desc_len = {8'd0, serial_len_reg};
                    usbep0_pkg::STR_CFGNAME: desc_len = {8'd0, cfgname_len_reg};
                    usbep0_pkg::STR_IFNAME:  desc_len = {8'd0, IFNAME_B};
                    default:                 desc_valid = 1'b0;
                endcase
            end
            default: desc_valid = 1'b0;
        endcase
    end

    always_comb
    begin
        item          = '0;
        item.cls      = usbep0_pkg::CLS_FIXED;
        item.action   = usbep0_pkg::ACT_NONE;
        item.addr     = req_value[6:0];
        item.idx_zero = (req_value[7:0] == 8'd0);
        item.idx_one  = (req_value[7:0] == 8'd1);
        if (op == usbep0_pkg::OP_IN_DONE)
        begin
            item.cls = usbep0_pkg::CLS_IN_DONE;
        end
        else if (recip == usbep0_pkg::RCP_DEVICE)
        begin
            if (type_kind == usbep0_pkg::TYPE_STANDARD)
            begin
                unique case (req_code)
                    usbep0_pkg::REQ_GET_DESCRIPTOR:
                    begin
                        if (!desc_valid)
                            item.action = usbep0_pkg::ACT_STALL;
                        else if (req_length == 16'd0)
                            item.action = usbep0_pkg::ACT_STATUS;
                        else if (desc_len != 16'd0)
                        begin
                            // clip to what the host asked for
                            item.action = usbep0_pkg::ACT_DATA;
                            item.kind   = desc_kind;
                            item.length = (desc_len < req_length) ? desc_len : req_length;
                        end
                    end
                    usbep0_pkg::REQ_SET_ADDRESS:
                    begin
                        item.cls = usbep0_pkg::CLS_SET_ADR;
                        item.ok  = (req_index == 16'd0) && (req_length == 16'd0)
                                   && !req_value[15] && (req_value[14:7] == 8'd0);
                    end
                    usbep0_pkg::REQ_SET_CONFIG:
                    begin
                        item.cls = usbep0_pkg::CLS_SET_CFG;
                        item.ok  = (req_value[7:0] <= MAX_CFG_B);
                    end
                    usbep0_pkg::REQ_GET_CONFIG:
                    begin
                        item.cls = usbep0_pkg::CLS_GET_CFG;
                        item.ok  = (req_length == 16'd1);
                    end
                    default: ;
                endcase
            end
        end
        else if (recip == usbep0_pkg::RCP_INTERFACE)
        begin
            item.cls = usbep0_pkg::CLS_IFACE;
            item.ok  = (type_kind != usbep0_pkg::TYPE_RESERVED)
                       && (req_index[7:0] <= MAX_IF_B);
        end
    end

endmodule

FILE: design/usbep0_fifo.sv
// ----------------------------------------------------------------------------
// usbep0_fifo
// Two-entry queue of classified requests between front and back end.
// ----------------------------------------------------------------------------
module usbep0_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  usbep0_pkg::ep0_item_t  push_item,
    output logic                   full,
    input  logic                   pop,
    output usbep0_pkg::ep0_item_t  pop_item,
    output logic                   empty
);

    usbep0_pkg::ep0_item_t mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: design/usbep0_back.sv
// ----------------------------------------------------------------------------
// usbep0_back
// Keeps device state and pending address, and registers one result per item.
// ----------------------------------------------------------------------------
module usbep0_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  usbep0_pkg::ep0_item_t  q_item,
    output logic                   q_pop,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output logic [2:0]             action,
    output logic [3:0]             desc_kind,
    output logic [15:0]            send_length,
    output logic                   config_value,
    output logic [1:0]             class_event,
    output logic                   apply_address,
    output logic [6:0]             device_address
);

    usbep0_pkg::usb_state_t   state_reg;
    usbep0_pkg::usb_state_t   state_next;
    logic [6:0]               pend_reg;
    logic [6:0]               pend_next;

    logic                     valid_reg;
    usbep0_pkg::action_t      action_reg;
    usbep0_pkg::action_t      action_next;
    logic [3:0]               kind_reg;
    logic [3:0]               kind_next;
    logic [15:0]              len_reg;
    logic [15:0]              len_next;
    logic                     cfgval_reg;
    logic                     cfgval_next;
    usbep0_pkg::class_event_t event_reg;
    usbep0_pkg::class_event_t event_next;
    logic                     apply_reg;
    logic                     apply_next;
    logic [6:0]               addr_reg;
    logic [6:0]               addr_next;

    // take the next item when the result slot is free or being emptied
    assign q_pop = !q_empty && (!valid_reg || !rsp_stall);

    // next state
    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        unique case (q_item.cls)
            usbep0_pkg::CLS_IN_DONE:
                pend_next = 7'd0;
            usbep0_pkg::CLS_SET_ADR:
            begin
                if (q_item.ok && state_reg != usbep0_pkg::ST_ADDRESSED)
                begin
                    state_next = usbep0_pkg::ST_ADDRESSED;
                    pend_next  = q_item.addr;
                end
            end
            usbep0_pkg::CLS_SET_CFG:
            begin
                if (q_item.ok)
                begin
                    if (state_reg == usbep0_pkg::ST_ADDRESSED && q_item.idx_one)
                        state_next = usbep0_pkg::ST_CONFIGURED;
                    else if (state_reg == usbep0_pkg::ST_CONFIGURED && q_item.idx_zero)
                        state_next = usbep0_pkg::ST_ADDRESSED;
                end
            end
            default: ;
        endcase
    end

    // result
    always_comb
    begin
        action_next = usbep0_pkg::ACT_NONE;
        kind_next   = '0;
        len_next    = '0;
        cfgval_next = 1'b0;
        event_next  = usbep0_pkg::EV_NONE;
        apply_next  = 1'b0;
        addr_next   = '0;
        unique case (q_item.cls)
            usbep0_pkg::CLS_IN_DONE:
            begin
                if (pend_reg != 7'd0)
                begin
                    apply_next = 1'b1;
                    addr_next  = pend_reg;
                end
            end
            usbep0_pkg::CLS_FIXED:
            begin
                action_next = q_item.action;
                kind_next   = q_item.kind;
                len_next    = q_item.length;
            end
            usbep0_pkg::CLS_SET_ADR:
            begin
                if (q_item.ok && state_reg != usbep0_pkg::ST_ADDRESSED)
                    action_next = usbep0_pkg::ACT_STATUS;
                else
                    action_next = usbep0_pkg::ACT_STALL;
            end
            usbep0_pkg::CLS_SET_CFG:
            begin
                if (!q_item.ok)
                    action_next = usbep0_pkg::ACT_STALL;
                else if (state_reg == usbep0_pkg::ST_ADDRESSED)
                begin
                    action_next = usbep0_pkg::ACT_STATUS;
                    if (q_item.idx_one)
                        event_next = usbep0_pkg::EV_INIT;
                end
                else if (state_reg == usbep0_pkg::ST_CONFIGURED)
                begin
                    action_next = usbep0_pkg::ACT_STATUS;
                    if (q_item.idx_zero)
                        event_next = usbep0_pkg::EV_DEINIT;
                end
                else
                begin
                    // not addressed yet
                    action_next = usbep0_pkg::ACT_STALL;
                    event_next  = usbep0_pkg::EV_DEINIT;
                end
            end
            usbep0_pkg::CLS_GET_CFG:
            begin
                if (q_item.ok && (state_reg == usbep0_pkg::ST_DEFAULT
                                  || state_reg == usbep0_pkg::ST_ADDRESSED
                                  || state_reg == usbep0_pkg::ST_CONFIGURED))
                begin
                    action_next = usbep0_pkg::ACT_DATA;
                    kind_next   = usbep0_pkg::KIND_CFG_BYTE;
                    len_next    = 16'd1;
                    cfgval_next = (state_reg == usbep0_pkg::ST_CONFIGURED);
                end
                else
                    action_next = usbep0_pkg::ACT_STALL;
            end
            usbep0_pkg::CLS_IFACE:
            begin
                if (q_item.ok && (state_reg == usbep0_pkg::ST_DEFAULT
                                  || state_reg == usbep0_pkg::ST_ADDRESSED
                                  || state_reg == usbep0_pkg::ST_CONFIGURED))
                    action_next = usbep0_pkg::ACT_FORWARD;
                else
                    action_next = usbep0_pkg::ACT_STALL;
            end
            default:
                action_next = usbep0_pkg::ACT_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= usbep0_pkg::ST_DEFAULT;
            pend_reg  <= 7'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                state_reg <= state_next;
                pend_reg  <= pend_next;
                valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            action_reg <= action_next;
            kind_reg   <= kind_next;
            len_reg    <= len_next;
            cfgval_reg <= cfgval_next;
            event_reg  <= event_next;
            apply_reg  <= apply_next;
            addr_reg   <= addr_next;
        end
    end

    assign rsp_valid      = valid_reg;
    assign action         = action_reg;
    assign desc_kind      = kind_reg;
    assign send_length    = len_reg;
    assign config_value   = cfgval_reg;
    assign class_event    = event_reg;
    assign apply_address  = apply_reg;
    assign device_address = addr_reg;

endmodule

FILE: design/usb_ep0_standard_request_handler_top.sv
// ----------------------------------------------------------------------------
// usb_ep0_standard_request_handler_top
// Endpoint zero standard request handler: decides one action per setup
// packet or IN completion, and tracks device state and pending address.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   ---------------------  -----------------------------------------
//  request   req_valid / req_stall  op, req_type, req_code, req_value,
//                                   req_index, req_length
//  result    rsp_valid / rsp_stall  action, desc_kind, send_length,
//                                   config_value, class_event,
//                                   apply_address, device_address
//  config    cfg_we                 cfg_index, cfg_data
//
//  one transfer per cycle in each direction while no stall holds it; a
//  request is classified by the front end into a two-entry queue, and the
//  back end applies device state and registers its result
//  reset clears device state, pending address, queue and result valid, and
//  loads the descriptor length registers with their defaults
//  rsp_stall holds the result register; the queue absorbs two more requests
//  before req_stall rises
//
module usb_ep0_standard_request_handler_top #(
    parameter int MAX_CONFIGS       = 1,
    parameter int MAX_INTERFACES    = 2,
    parameter int IFNAME_STR_LENGTH = 0
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        op,
    input  logic [7:0]  req_type,
    input  logic [7:0]  req_code,
    input  logic [15:0] req_value,
    input  logic [15:0] req_index,
    input  logic [15:0] req_length,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [2:0]  action,
    output logic [3:0]  desc_kind,
    output logic [15:0] send_length,
    output logic        config_value,
    output logic [1:0]  class_event,
    output logic        apply_address,
    output logic [6:0]  device_address
);

    usbep0_pkg::ep0_item_t front_item;
    usbep0_pkg::ep0_item_t q_item;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_pop;
    logic                  q_push;

    assign req_stall = q_full;
    assign q_push    = req_valid && !q_full;

    usbep0_front #(
        .MAX_CONFIGS       (MAX_CONFIGS),
        .MAX_INTERFACES    (MAX_INTERFACES),
        .IFNAME_STR_LENGTH (IFNAME_STR_LENGTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .op         (op),
        .req_type   (req_type),
        .req_code   (req_code),
        .req_value  (req_value),
        .req_index  (req_index),
        .req_length (req_length),
        .item       (front_item)
    );

    usbep0_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_item),
        .empty     (q_empty)
    );

    usbep0_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .action         (action),
        .desc_kind      (desc_kind),
        .send_length    (send_length),
        .config_value   (config_value),
        .class_event    (class_event),
        .apply_address  (apply_address),
        .device_address (device_address)
    );

endmodule
